// ----- sv/abas_pkg.sv -----
// Shared constants, types and fixed-point scaling factors of the ADC block average scaler.
package abas_pkg;

  localparam int NCH_MAX    = 6;
  localparam int DEF_DEPTH  = 15;

  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 18;
  localparam int CNT_W      = 6;
  localparam int AVG_W      = 12;
  localparam int SIG_W      = 21;
  localparam int ENG_W      = 32;
  localparam int LP_W       = 16;
  localparam int CH_W       = 3;
  localparam int LOW_W      = 22;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int SETUP_W    = 56;

  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE = 3'd6;

  // 4-20 mA: avg * 22 * 65536 / 4096
  localparam int MA_SCALE   = 352;

  // Voltage inputs: round(avg * k * 65536 / 4090) == floor((avg * k/10 * 65536 + 204) / 409)
  localparam int VOLT_SH5   = 15;
  localparam int VOLT_SH10  = 16;
  localparam int VOLT_RND   = 204;
  localparam int VOLT_DIV   = 409;
  localparam int VNUM_W     = 28;
  localparam int VOLT_K     = 37;
  localparam int VRECIP_W   = 29;
  localparam logic [VRECIP_W-1:0] VOLT_RECIP =
    VRECIP_W'(((64'd1 << VOLT_K) + VOLT_DIV - 1) / VOLT_DIV);

  localparam int DIFF_W     = 23;
  localparam int ENGP_W     = DIFF_W + ENG_W;
  localparam int FRAC_W     = 16;
  localparam int FLOOR_W    = ENGP_W - FRAC_W;

  typedef enum logic [1:0] {
    TYPE_NONE = 2'd0,
    TYPE_MA   = 2'd1,
    TYPE_5V   = 2'd2,
    TYPE_10V  = 2'd3
  } in_type_e;

  typedef struct packed {
    logic signed [ENG_W-1:0] gain;
    logic [LOW_W-1:0]        low;
    in_type_e                typ;
  } chan_setup_t;

  typedef struct packed {
    logic accept;
    logic fire;
    logic st_div;
    logic st_conv;
    logic st_eng;
  } lane_ctrl_t;

  typedef struct packed {
    logic [AVG_W-1:0]        average;
    logic [SIG_W-1:0]        signal_value;
    logic signed [ENG_W-1:0] eng_value;
  } lane_res_t;

endpackage

// ----- sv/abas_if.sv -----
// Valid/ready channel interfaces for scans, results and configuration writes.
interface abas_scan_if;
  logic                          valid;
  logic                          ready;
  logic [abas_pkg::SAMPLE_W-1:0] sample_a;
  logic [abas_pkg::SAMPLE_W-1:0] sample_b;
  logic [abas_pkg::SAMPLE_W-1:0] sample_c;
  logic [abas_pkg::SAMPLE_W-1:0] sample_d;
  logic [abas_pkg::SAMPLE_W-1:0] sample_e;
  logic [abas_pkg::SAMPLE_W-1:0] sample_f;

  modport source (output valid, sample_a, sample_b, sample_c, sample_d, sample_e, sample_f,
                  input ready);
  modport sink (input valid, sample_a, sample_b, sample_c, sample_d, sample_e, sample_f,
                output ready);
endinterface

interface abas_result_if;
  logic                               valid;
  logic                               ready;
  logic [abas_pkg::CH_W-1:0]          channel;
  logic [abas_pkg::AVG_W-1:0]         average;
  logic [abas_pkg::SIG_W-1:0]         signal_value;
  logic signed [abas_pkg::ENG_W-1:0]  eng_value;
  logic [abas_pkg::LP_W-1:0]          line_pressure;
  logic                               last;

  modport source (output valid, channel, average, signal_value, eng_value, line_pressure, last,
                  input ready);
  modport sink (input valid, channel, average, signal_value, eng_value, line_pressure, last,
                output ready);
endinterface

interface abas_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [abas_pkg::CFG_IDX_W-1:0]  index;
  logic [abas_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/abas_lane.sv -----
// One channel lane: running sum, block average, signal conversion and engineering scaling.
module abas_lane #(
  parameter int DEPTH = abas_pkg::DEF_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  abas_pkg::lane_ctrl_t          ctrl_i,
  input  logic [abas_pkg::SAMPLE_W-1:0] sample_i,
  input  abas_pkg::chan_setup_t         setup_i,
  output abas_pkg::lane_res_t           res_o
);
  import abas_pkg::*;

  // floor(sum / DEPTH) as a reciprocal multiply, exact for any 18-bit sum
  localparam int AVG_K  = SUM_W + CNT_W;
  localparam int AVG_RW = AVG_K + 1;
  localparam logic [AVG_RW-1:0] AVG_RECIP = AVG_RW'(((64'd1 << AVG_K) + DEPTH - 1) / DEPTH);
  localparam int DIVP_W = SUM_W + AVG_RW;
  localparam int VOLTP_W = VOLT_K + SIG_W;

  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [DIVP_W-1:0]         divp_q;
  logic [AVG_W-1:0]          avg, avg_q;
  logic [VNUM_W-1:0]         volt_num;
  logic [VOLTP_W-1:0]        voltp_q;
  logic [SIG_W-1:0]          ma_q;
  logic [SIG_W-1:0]          sig, sig_q;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ENGP_W-1:0]  engp_d, engp_q;
  logic signed [FLOOR_W-1:0] eng_fl;
  logic signed [ENG_W-1:0]   eng_sat, eng_q;
  logic                      active;

  assign active = (setup_i.typ != TYPE_NONE);
  assign sum_d  = sum_q + SUM_W'(sample_i);
  assign avg    = divp_q[AVG_K +: AVG_W];

  always_comb begin
    if (setup_i.typ == TYPE_5V) begin
      volt_num = (VNUM_W'(avg) << VOLT_SH5) + VNUM_W'(VOLT_RND);
    end else begin
      volt_num = (VNUM_W'(avg) << VOLT_SH10) + VNUM_W'(VOLT_RND);
    end
  end

  assign sig    = (setup_i.typ == TYPE_MA) ? ma_q : voltp_q[VOLT_K +: SIG_W];
  assign diff   = $signed({2'b00, sig}) - $signed({1'b0, setup_i.low});
  assign engp_d = diff * setup_i.gain;
  // arithmetic shift of the Q32.32 product floors it to Q16.16
  assign eng_fl = engp_q[ENGP_W-1:FRAC_W];

  always_comb begin
    if ((&eng_fl[FLOOR_W-1:ENG_W-1]) || !(|eng_fl[FLOOR_W-1:ENG_W-1])) begin
      eng_sat = eng_fl[ENG_W-1:0];
    end else if (eng_fl[FLOOR_W-1]) begin
      eng_sat = {1'b1, {(ENG_W-1){1'b0}}};
    end else begin
      eng_sat = {1'b0, {(ENG_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sig_q <= '0;
      eng_q <= '0;
    end else begin
      if (ctrl_i.accept) begin
        sum_q <= ctrl_i.fire ? '0 : sum_d;
      end
      // type none keeps the previous signal and engineering value
      if (ctrl_i.st_conv && active) begin
        sig_q <= sig;
      end
      if (ctrl_i.st_eng && active) begin
        eng_q <= eng_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && ctrl_i.fire) begin
      divp_q <= DIVP_W'(sum_d * AVG_RECIP);
    end
    if (ctrl_i.st_div) begin
      avg_q   <= avg;
      voltp_q <= VOLTP_W'(volt_num * VOLT_RECIP);
      ma_q    <= SIG_W'(SIG_W'(avg) * SIG_W'(MA_SCALE));
    end
    if (ctrl_i.st_conv) begin
      engp_q <= engp_d;
    end
  end

  assign res_o.average      = avg_q;
  assign res_o.signal_value = sig_q;
  assign res_o.eng_value    = eng_q;

endmodule

// ----- sv/abas_merge.sv -----
// Merge stage: line pressure pick and serial emission of per-channel results.
module abas_merge #(
  parameter int CHANNELS = abas_pkg::NCH_MAX
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [abas_pkg::CH_W-1:0] pressure_channel_i,
  input  abas_pkg::lane_res_t       res_i [CHANNELS],
  output logic                      done_o,
  abas_result_if.source             res_o
);
  import abas_pkg::*;

  logic [CH_W-1:0] idx_q, idx_d;
  logic            valid_q;
  logic [LP_W-1:0] lp_q, lp_new, lp_sel;
  lane_res_t       pick;
  logic            pick_last;
  logic            xfer, load;

  logic [CH_W-1:0]         ch_q;
  logic [AVG_W-1:0]        avg_q;
  logic [SIG_W-1:0]        sig_q;
  logic signed [ENG_W-1:0] eng_q;
  logic [LP_W-1:0]         lpo_q;
  logic                    last_q;

  assign xfer = valid_q && res_o.ready;
  assign load = start_i || (xfer && !last_q);
  assign idx_d = start_i ? '0 : idx_q + CH_W'(1);
  assign pick_last = (idx_d == CH_W'(CHANNELS - 1));

  always_comb begin
    pick   = '0;
    lp_new = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (idx_d == CH_W'(i)) begin
        pick = res_i[i];
      end
      // negative or zero reads as zero; a positive Q16.16 integer part fits 16 bits
      if (pressure_channel_i == CH_W'(i) && res_i[i].eng_value > 0) begin
        lp_new = res_i[i].eng_value[ENG_W-1:FRAC_W];
      end
    end
  end

  assign lp_sel = start_i ? lp_new : lp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= idx_d;
    end else if (xfer) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      lp_q   <= lp_sel;
      ch_q   <= idx_d;
      avg_q  <= pick.average;
      sig_q  <= pick.signal_value;
      eng_q  <= pick.eng_value;
      lpo_q  <= lp_sel;
      last_q <= pick_last;
    end
  end

  assign done_o              = xfer && last_q;
  assign res_o.valid         = valid_q;
  assign res_o.channel       = ch_q;
  assign res_o.average       = avg_q;
  assign res_o.signal_value  = sig_q;
  assign res_o.eng_value     = eng_q;
  assign res_o.line_pressure = lpo_q;
  assign res_o.last          = last_q;

endmodule

// ----- sv/adc_block_average_scaler_top.sv -----
// Top level of the six-channel ADC block average scaler.
// Each accepted scan adds one 12-bit sample per channel to that channel's running sum. A scan
// that does not complete a block of DEPTH scans gives no result. The scan that completes a block
// starts the lane pipeline: the reciprocal divide by DEPTH, the mA/V conversion multiply, the
// gain multiply, saturation into the stores, then the merge stage picks line pressure; after
// that CHANNELS results leave through the output register, one transfer per cycle while the
// sink is ready. Scans that do not complete a block are still taken while those results drain.
// The asynchronous reset clears control state, sums, configuration and signal/engineering stores,
// so there is no clearing pass; configuration must be written while idle, not enforced by the block.
module adc_block_average_scaler_top #(
  parameter int CHANNELS = abas_pkg::NCH_MAX,
  parameter int DEPTH    = abas_pkg::DEF_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  abas_scan_if.sink     scan_i,
  abas_cfg_if.sink      cfg_i,
  abas_result_if.source res_o
);
  import abas_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CONV,
    ST_ENG,
    ST_PRESS,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  scan_q, scan_nxt;
  logic              fire, accept, emit_done;
  lane_ctrl_t        ctrl;
  chan_setup_t       setup_q [NCH_MAX];
  logic [CH_W-1:0]   pch_q;
  logic [SAMPLE_W-1:0] smp [NCH_MAX];
  lane_res_t         res [CHANNELS];

  assign smp[0] = scan_i.sample_a;
  assign smp[1] = scan_i.sample_b;
  assign smp[2] = scan_i.sample_c;
  assign smp[3] = scan_i.sample_d;
  assign smp[4] = scan_i.sample_e;
  assign smp[5] = scan_i.sample_f;

  // 6-bit counter wraps as in the block spec, so DEPTH of 64 never closes a block
  assign scan_nxt = scan_q + CNT_W'(1);
  assign fire     = ({1'b0, scan_nxt} >= (CNT_W + 1)'(DEPTH));

  assign scan_i.ready = (state_q == ST_IDLE) || (state_q == ST_EMIT && !fire);
  assign accept       = scan_i.valid && scan_i.ready;

  assign ctrl.accept  = accept;
  assign ctrl.fire    = fire;
  assign ctrl.st_div  = (state_q == ST_DIV);
  assign ctrl.st_conv = (state_q == ST_CONV);
  assign ctrl.st_eng  = (state_q == ST_ENG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= '0;
    end else begin
      if (accept) begin
        scan_q <= fire ? '0 : scan_nxt;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && fire) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV:   state_q <= ST_CONV;
        ST_CONV:  state_q <= ST_ENG;
        ST_ENG:   state_q <= ST_PRESS;
        ST_PRESS: state_q <= ST_EMIT;
        ST_EMIT: begin
          if (emit_done) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH_MAX; i++) begin
        setup_q[i] <= '0;
      end
      pch_q <= '0;
    end else if (cfg_i.valid) begin
      // writes beyond the register list are dropped
      if (cfg_i.index < CFG_IDX_W'(NCH_MAX)) begin
        setup_q[cfg_i.index] <= chan_setup_t'(cfg_i.data[SETUP_W-1:0]);
      end else if (cfg_i.index == REG_PRESSURE) begin
        pch_q <= cfg_i.data[CH_W-1:0];
      end
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    abas_lane #(
      .DEPTH(DEPTH)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .sample_i(smp[g]),
      .setup_i (setup_q[g]),
      .res_o   (res[g])
    );
  end

  abas_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (state_q == ST_PRESS),
    .pressure_channel_i(pch_q),
    .res_i             (res),
    .done_o            (emit_done),
    .res_o             (res_o)
  );

endmodule
